// ===== src/mnmd_pkg.sv =====
// Package for the mixed-number multiply/divide to decimal text block.
package mnmd_pkg;

  localparam int unsigned MAX_LEN_DEF = 64;
  localparam logic [6:0] RESULT_LENGTH_RESET = 7'd16;
  localparam logic [30:0] LIM31 = 31'h7FFF_FFFF;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic CMD_MUL = 1'b0;
  localparam logic CMD_DIV = 1'b1;

  // Classified operation handed from the front part to the back part.
  typedef struct packed {
    logic        err;
    logic        neg;
    logic [30:0] n;
    logic [30:0] d;
  } op_t;

  typedef enum logic [1:0] {
    FS_IDLE, FS_IMP, FS_PROD, FS_PUSH
  } fstate_t;

  typedef enum logic [3:0] {
    BS_IDLE, BS_DIV, BS_DIG, BS_SIZE, BS_SIGN, BS_WHOLE, BS_DOT,
    BS_FRAC, BS_FDIV, BS_TERM, BS_ERR
  } bstate_t;

endpackage

// ===== src/mnmd_front.sv =====
// Front part: accepts items, forms improper fractions and the product, flags errors.
module mnmd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic signed [31:0]   in_whole_a,
  input  logic [30:0]          in_num_a,
  input  logic [30:0]          in_den_a,
  input  logic signed [31:0]   in_whole_b,
  input  logic [30:0]          in_num_b,
  input  logic [30:0]          in_den_b,
  output logic                 op_valid,
  input  logic                 op_ready,
  output mnmd_pkg::op_t        op
);

  mnmd_pkg::fstate_t state_r, state_nxt;
  logic        cmd_r;
  logic        neg_r;
  logic        err_r, err_nxt;
  logic [31:0] mag_a_r, mag_b_r;
  logic [30:0] na_r, da_r, nb_r, db_r;
  logic [63:0] ia_r, ib_r, n_r, d_r;
  logic [63:0] mn, md;

  // Multiplier choice for the product: the reciprocal swaps numerator and denominator.
  always_comb begin
    if (cmd_r == mnmd_pkg::CMD_DIV) begin
      mn = {33'd0, db_r};
      md = ib_r;
    end else begin
      mn = ib_r;
      md = {33'd0, db_r};
    end
  end

  // Register state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mnmd_pkg::FS_IDLE;
      err_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      err_r <= err_nxt;
    end
  end

  // Datapath registers, one multiply per operand per step.
  always_ff @(posedge clk) begin
    case (state_r)
      mnmd_pkg::FS_IDLE: begin
        cmd_r <= in_cmd;
        neg_r <= in_whole_a[31] ^ in_whole_b[31];
        mag_a_r <= in_whole_a[31] ? 32'(-in_whole_a) : in_whole_a;
        mag_b_r <= in_whole_b[31] ? 32'(-in_whole_b) : in_whole_b;
        na_r <= in_num_a;
        da_r <= in_den_a;
        nb_r <= in_num_b;
        db_r <= in_den_b;
      end
      mnmd_pkg::FS_IMP: begin
        ia_r <= {32'd0, mag_a_r} * {33'd0, da_r} + {33'd0, na_r};
        ib_r <= {32'd0, mag_b_r} * {33'd0, db_r} + {33'd0, nb_r};
      end
      mnmd_pkg::FS_PROD: begin
        n_r <= {32'd0, ia_r[31:0]} * {32'd0, mn[31:0]};
        d_r <= {33'd0, da_r} * {32'd0, md[31:0]};
      end
      default: ;
    endcase
  end

  // Next state and error flag.
  always_comb begin
    state_nxt = state_r;
    err_nxt = err_r;
    in_ready = 1'b0;
    op_valid = 1'b0;
    case (state_r)
      mnmd_pkg::FS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = mnmd_pkg::FS_IMP;
          err_nxt = (in_den_a == 31'd0) || (in_den_b == 31'd0);
        end
      end
      mnmd_pkg::FS_IMP: state_nxt = mnmd_pkg::FS_PROD;
      mnmd_pkg::FS_PROD: begin
        state_nxt = mnmd_pkg::FS_PUSH;
        if (ia_r > 64'(mnmd_pkg::LIM31) || ib_r > 64'(mnmd_pkg::LIM31)) err_nxt = 1'b1;
        else if (cmd_r == mnmd_pkg::CMD_DIV && ib_r == 64'd0) err_nxt = 1'b1;
      end
      mnmd_pkg::FS_PUSH: begin
        op_valid = 1'b1;
        if (op_ready) state_nxt = mnmd_pkg::FS_IDLE;
      end
      default: state_nxt = mnmd_pkg::FS_IDLE;
    endcase
  end

  always_comb begin
    op.neg = neg_r;
    op.n = n_r[30:0];
    op.d = d_r[30:0];
    op.err = err_r || (n_r > 64'(mnmd_pkg::LIM31)) || (d_r > 64'(mnmd_pkg::LIM31))
             || (d_r == 64'd0);
  end

endmodule

// ===== src/mnmd_queue.sv =====
// Two-entry queue between the front and back parts.
module mnmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  mnmd_pkg::op_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output mnmd_pkg::op_t rd_data
);

  mnmd_pkg::op_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule

// ===== src/mnmd_back.sv =====
// Back part: divides, sizes the text and emits it one character at a time.
module mnmd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [6:0]    len_eff,
  input  logic          op_valid,
  output logic          op_ready,
  input  mnmd_pkg::op_t op,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          out_last,
  output logic          out_ok
);

  mnmd_pkg::bstate_t state_r, state_nxt;
  logic        neg_r;
  logic [30:0] d_r;
  logic [30:0] q_r;      // quotient of the current division
  logic [30:0] rem_r;    // partial remainder
  logic [30:0] dvd_r;    // dividend being shifted in
  logic [4:0]  bit_r;
  logic [30:0] r_r;
  logic [30:0] t_r;
  logic [3:0]  nd_r;     // number of whole digits
  logic [3:0]  di_r;
  logic [39:0] dig_r;    // whole digits, least significant first, 4 bits each
  logic [6:0]  size_r, pos_r;
  logic        hold_r;   // output register full
  logic [7:0]  ch_r;
  logic        last_r, ok_r;
  logic        ld;
  logic [7:0]  ld_ch;
  logic        ld_last, ld_ok;
  logic [31:0] trial;
  logic [34:0] fr10;
  logic [62:0] t_mul;
  logic [27:0] t_q;
  logic [3:0]  t_dig;

  assign out_valid = hold_r;
  assign out_char = ch_r;
  assign out_last = last_r;
  assign out_ok = ok_r;
  assign trial = {rem_r, dvd_r[30]};
  assign fr10 = {1'b0, r_r, 3'd0} + {3'd0, r_r, 1'b0};

  // Division by ten of the whole part through a reciprocal multiplication.
  assign t_mul = {32'd0, t_r} * {31'd0, 32'hCCCC_CCCD};
  assign t_q = t_mul[62:35];
  assign t_dig = t_r[3:0] - {t_q[0], 3'd0} - {t_q[2:0], 1'b0};

  // Output register, free when empty or being taken.
  logic slot;
  assign slot = !hold_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (ld) begin
      hold_r <= 1'b1;
    end else if (out_ready) begin
      hold_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      ch_r <= ld_ch;
      last_r <= ld_last;
      ok_r <= ld_ok;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mnmd_pkg::BS_IDLE;
    else state_r <= state_nxt;
  end

  // Datapath: restoring divider shared by the whole-part division (31 steps) and
  // the fraction digits (4 steps each), and a digit extractor for the whole part.
  always_ff @(posedge clk) begin
    case (state_r)
      mnmd_pkg::BS_IDLE: begin
        neg_r <= op.neg;
        d_r <= op.d;
        dvd_r <= op.n;
        rem_r <= 31'd0;
        bit_r <= 5'd30;
      end
      mnmd_pkg::BS_DIV, mnmd_pkg::BS_FDIV: begin
        // The divider stops once all steps are done, also while a digit waits.
        if (bit_r != 5'd31) begin
          dvd_r <= {dvd_r[29:0], 1'b0};
          if (trial >= {1'b0, d_r}) begin
            rem_r <= 31'(trial - {1'b0, d_r});
            q_r <= {q_r[29:0], 1'b1};
          end else begin
            rem_r <= trial[30:0];
            q_r <= {q_r[29:0], 1'b0};
          end
          bit_r <= bit_r - 5'd1;
          if (state_r == mnmd_pkg::BS_DIV && bit_r == 5'd0) begin
            nd_r <= 4'd0;
            dig_r <= 40'd0;
          end
        end
      end
      default: ;
    endcase
    // Captures at the end of a division.
    if (state_r == mnmd_pkg::BS_DIV && bit_r == 5'd31) begin
      t_r <= q_r;
      r_r <= rem_r;
    end
    if (state_r == mnmd_pkg::BS_FDIV && bit_r == 5'd31) begin
      r_r <= rem_r;
    end
    if (state_r == mnmd_pkg::BS_DIG) begin
      dig_r[4 * nd_r +: 4] <= t_dig;
      t_r <= {3'd0, t_q};
      nd_r <= nd_r + 4'd1;
    end
    if (state_r == mnmd_pkg::BS_SIZE) begin
      size_r <= 7'(nd_r) + 7'(neg_r);
      di_r <= nd_r;
      pos_r <= 7'd0;
    end
    if (ld) pos_r <= pos_r + 7'd1;
    if (ld && state_r == mnmd_pkg::BS_WHOLE) di_r <= di_r - 4'd1;
    // Ten times the remainder is below sixteen times the divisor, so its top bits
    // form the starting remainder and only four quotient bits are left.
    if (state_r == mnmd_pkg::BS_FRAC) begin
      rem_r <= fr10[34:4];
      dvd_r <= {fr10[3:0], 27'd0};
      bit_r <= 5'd3;
    end
  end

  // Next state and character loads.
  always_comb begin
    state_nxt = state_r;
    op_ready = 1'b0;
    ld = 1'b0;
    ld_ch = mnmd_pkg::CHAR_NUL;
    ld_last = 1'b0;
    ld_ok = 1'b0;
    case (state_r)
      mnmd_pkg::BS_IDLE: begin
        op_ready = 1'b1;
        if (op_valid) state_nxt = op.err ? mnmd_pkg::BS_ERR : mnmd_pkg::BS_DIV;
      end
      mnmd_pkg::BS_DIV: begin
        if (bit_r == 5'd31) state_nxt = mnmd_pkg::BS_DIG;
      end
      mnmd_pkg::BS_DIG: begin
        if (t_r < 31'd10) state_nxt = mnmd_pkg::BS_SIZE;
      end
      mnmd_pkg::BS_SIZE: begin
        if (7'(nd_r) + 7'(neg_r) >= len_eff) state_nxt = mnmd_pkg::BS_ERR;
        else state_nxt = neg_r ? mnmd_pkg::BS_SIGN : mnmd_pkg::BS_WHOLE;
      end
      mnmd_pkg::BS_SIGN: begin
        if (slot) begin
          ld = 1'b1;
          ld_ch = mnmd_pkg::CHAR_MINUS;
          state_nxt = mnmd_pkg::BS_WHOLE;
        end
      end
      mnmd_pkg::BS_WHOLE: begin
        if (slot) begin
          ld = 1'b1;
          ld_ch = mnmd_pkg::CHAR_ZERO | {4'd0, dig_r[4 * (di_r - 4'd1) +: 4]};
          if (di_r == 4'd1)
            state_nxt = (size_r + 7'd2 >= len_eff) ? mnmd_pkg::BS_TERM : mnmd_pkg::BS_DOT;
        end
      end
      mnmd_pkg::BS_DOT: begin
        if (slot) begin
          ld = 1'b1;
          ld_ch = mnmd_pkg::CHAR_DOT;
          state_nxt = mnmd_pkg::BS_FRAC;
        end
      end
      mnmd_pkg::BS_FRAC: state_nxt = mnmd_pkg::BS_FDIV;
      mnmd_pkg::BS_FDIV: begin
        if (bit_r == 5'd31 && slot) begin
          ld = 1'b1;
          ld_ch = mnmd_pkg::CHAR_ZERO | {4'd0, q_r[3:0]};
          state_nxt = (pos_r + 7'd2 >= len_eff) ? mnmd_pkg::BS_TERM : mnmd_pkg::BS_FRAC;
        end
      end
      mnmd_pkg::BS_TERM: begin
        if (slot) begin
          ld = 1'b1;
          ld_last = 1'b1;
          ld_ok = 1'b1;
          state_nxt = mnmd_pkg::BS_IDLE;
        end
      end
      mnmd_pkg::BS_ERR: begin
        if (slot) begin
          ld = 1'b1;
          ld_last = 1'b1;
          state_nxt = mnmd_pkg::BS_IDLE;
        end
      end
      default: state_nxt = mnmd_pkg::BS_IDLE;
    endcase
  end

endmodule

// ===== src/mixed_number_mul_div_to_decimal_top.sv =====
// Top level of the mixed-number multiply/divide to decimal text block.
// Input channel in_*: one transaction carries a command and two mixed numbers.
// Output channel out_*: one transaction per character of the result text, the
// last one being the terminator, with out_last set and out_ok giving success.
// On error a single terminator transaction with out_ok low is sent.
// Configuration: cfg_we writes cfg_result_length, the buffer length with
// terminator; it is clipped to MAX_LEN.
// The front part steps through accept, improper fractions, product and
// hand-over to the queue for each item; the hand-over waits for queue space.
// The back part runs a one-bit-per-cycle restoring divider: it divides for the
// whole part, extracts each whole digit and sends it, then per fraction digit
// runs a set-up, four divide steps and a send. A two-entry queue lets the front
// accept the next item while the back still emits.
// Reset clears the sequencers, queue and output register; the length
// register returns to 16. When the receiver stalls, the back part holds the
// pending character and waits; the front and queue keep filling.
module mixed_number_mul_div_to_decimal_top #(
  parameter int unsigned MAX_LEN = mnmd_pkg::MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_result_length,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic signed [31:0]  in_whole_a,
  input  logic [30:0]         in_num_a,
  input  logic [30:0]         in_den_a,
  input  logic signed [31:0]  in_whole_b,
  input  logic [30:0]         in_num_b,
  input  logic [30:0]         in_den_b,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic                out_last,
  output logic                out_ok
);

  logic [6:0] len_r;
  logic [6:0] len_eff;
  logic f_valid, f_ready, b_valid, b_ready;
  mnmd_pkg::op_t f_op, b_op;

  // Length register and its clip.
  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= mnmd_pkg::RESULT_LENGTH_RESET;
    else if (cfg_we) len_r <= cfg_result_length;
  end
  assign len_eff = (len_r < 7'(MAX_LEN)) ? len_r : 7'(MAX_LEN);

  mnmd_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_whole_a, .in_num_a,
    .in_den_a, .in_whole_b, .in_num_b, .in_den_b,
    .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
  );

  mnmd_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_op),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_op)
  );

  mnmd_back u_back (
    .clk, .rst_n, .len_eff, .op_valid(b_valid), .op_ready(b_ready), .op(b_op),
    .out_valid, .out_ready, .out_char, .out_last, .out_ok
  );

endmodule

// ===== verif/tb_mixed_number_mul_div_to_decimal_top.sv =====
// Self-checking testbench for the mixed-number multiply/divide to decimal text block.
`timescale 1ns / 100ps

module tb_mixed_number_mul_div_to_decimal_top;

  localparam int unsigned TEXT_MAX = 64;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam longint CYCLE_LIMIT = 1500000;

  // One input transaction.
  typedef struct {
    logic        cmd;
    logic [31:0] whole_a;
    logic [30:0] num_a;
    logic [30:0] den_a;
    logic [31:0] whole_b;
    logic [30:0] num_b;
    logic [30:0] den_b;
  } operands_t;

  // One character of result text.
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       ok;
  } text_char_t;

  // A directed row; known_fail marks rows whose result is an error terminator.
  typedef struct {
    operands_t ops;
    logic      known_fail;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [6:0]  cfg_result_length;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [31:0] in_whole_a;
  logic [30:0] in_num_a;
  logic [30:0] in_den_a;
  logic [31:0] in_whole_b;
  logic [30:0] in_num_b;
  logic [30:0] in_den_b;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_char;
  logic        out_last;
  logic        out_ok;

  text_char_t  expected_text[$];
  logic [6:0]  buffer_length;
  int          mismatch_count;
  int          chars_seen;
  int          items_sent;
  int          error_items;
  longint      cycle_count = 0;
  bit          long_hold;

  mixed_number_mul_div_to_decimal_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_result_length (cfg_result_length),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_whole_a        (in_whole_a),
    .in_num_a          (in_num_a),
    .in_den_a          (in_den_a),
    .in_whole_b        (in_whole_b),
    .in_num_b          (in_num_b),
    .in_den_b          (in_den_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_last          (out_last),
    .out_ok            (out_ok)
  );

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the overall cycle count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Appends one error terminator to the expectations.
  function automatic void push_error();
    text_char_t t;
    t.ch = mnmd_pkg::CHAR_NUL;
    t.last = 1'b1;
    t.ok = 1'b0;
    expected_text.push_back(t);
    error_items++;
  endfunction

  // Works out the decimal text of the product or quotient and queues it.
  function automatic void predict_decimal_text(operands_t op);
    logic [63:0] mag_a, mag_b, imp_a, imp_b, mul_n, mul_d, prod_n, prod_d;
    logic [63:0] whole, frac_rem, scratch;
    logic        neg;
    int          size, len, count;
    logic [7:0]  text[TEXT_MAX];
    text_char_t  t;

    mag_a = op.whole_a[31] ? 64'h1_0000_0000 - {32'd0, op.whole_a} : {32'd0, op.whole_a};
    mag_b = op.whole_b[31] ? 64'h1_0000_0000 - {32'd0, op.whole_b} : {32'd0, op.whole_b};
    neg = op.whole_a[31] ^ op.whole_b[31];
    if (op.den_a == 0 || op.den_b == 0) begin
      push_error();
      return;
    end
    imp_a = mag_a * {33'd0, op.den_a} + {33'd0, op.num_a};
    imp_b = mag_b * {33'd0, op.den_b} + {33'd0, op.num_b};
    if (imp_a > 64'(mnmd_pkg::LIM31) || imp_b > 64'(mnmd_pkg::LIM31)) begin
      push_error();
      return;
    end
    if (op.cmd == mnmd_pkg::CMD_DIV) begin
      if (imp_b == 0) begin
        push_error();
        return;
      end
      mul_n = {33'd0, op.den_b};
      mul_d = imp_b;
    end else begin
      mul_n = imp_b;
      mul_d = {33'd0, op.den_b};
    end
    prod_n = imp_a * mul_n;
    prod_d = {33'd0, op.den_a} * mul_d;
    if (prod_n > 64'(mnmd_pkg::LIM31) || prod_d > 64'(mnmd_pkg::LIM31) || prod_d == 0) begin
      push_error();
      return;
    end
    whole = prod_n / prod_d;
    frac_rem = prod_n % prod_d;

    size = 1;
    for (scratch = whole; scratch >= 10; scratch = scratch / 10) size++;
    if (neg) size++;
    len = (buffer_length < TEXT_MAX) ? int'(buffer_length) : int'(TEXT_MAX);
    if (size >= len) begin
      push_error();
      return;
    end

    // Sign and whole digits, written from the right.
    if (neg) text[0] = mnmd_pkg::CHAR_MINUS;
    scratch = whole;
    for (int i = size; i > (neg ? 1 : 0); i--) begin
      text[i - 1] = mnmd_pkg::CHAR_ZERO + 8'(scratch % 10);
      scratch = scratch / 10;
    end

    // The fraction appears only when at least one digit fits.
    if (size + 2 >= len) begin
      text[size] = mnmd_pkg::CHAR_NUL;
      count = size + 1;
    end else begin
      text[size] = mnmd_pkg::CHAR_DOT;
      for (int i = size + 1; i < len - 1; i++) begin
        frac_rem = frac_rem * 10;
        text[i] = mnmd_pkg::CHAR_ZERO + 8'(frac_rem / prod_d);
        frac_rem = frac_rem % prod_d;
      end
      text[len - 1] = mnmd_pkg::CHAR_NUL;
      count = len;
    end

    for (int k = 0; k < count; k++) begin
      t.ch = text[k];
      t.last = (k + 1 == count);
      t.ok = (k + 1 == count);
      expected_text.push_back(t);
    end
  endfunction

  // Random operands: mostly small well-formed values, some at full width.
  function automatic operands_t random_operands();
    operands_t op;
    int        mode;
    mode = $urandom_range(0, 9);
    op.cmd = 1'($urandom_range(0, 1));
    if (mode < 7) begin
      op.whole_a = $urandom_range(0, 200);
      op.whole_b = $urandom_range(0, 200);
      if ($urandom_range(0, 1)) op.whole_a = -op.whole_a;
      if ($urandom_range(0, 1)) op.whole_b = -op.whole_b;
      op.den_a = 31'($urandom_range(1, 300));
      op.den_b = 31'($urandom_range(1, 300));
      op.num_a = 31'($urandom_range(0, op.den_a));
      op.num_b = 31'($urandom_range(0, op.den_b));
    end else if (mode < 9) begin
      op.whole_a = $urandom_range(0, 40000) - 20000;
      op.whole_b = $urandom_range(0, 60) - 30;
      op.den_a = 31'($urandom_range(1, 7));
      op.den_b = 31'($urandom_range(1, 7));
      op.num_a = 31'($urandom_range(0, 10));
      op.num_b = 31'($urandom_range(0, 10));
    end else begin
      // Full-width noise, mostly errors.
      op.whole_a = $urandom;
      op.whole_b = $urandom;
      op.num_a = 31'($urandom);
      op.num_b = 31'($urandom);
      op.den_a = 31'($urandom);
      op.den_b = 31'($urandom);
    end
    return op;
  endfunction

  // Offers one transaction and holds it until it is accepted; valid stays high
  // into the next transaction when no idle gap is drawn.
  task automatic send_item(operands_t op);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= op.cmd;
    in_whole_a <= op.whole_a;
    in_num_a   <= op.num_a;
    in_den_a   <= op.den_a;
    in_whole_b <= op.whole_b;
    in_num_b   <= op.num_b;
    in_den_b   <= op.den_b;
    do @(posedge clk); while (!in_ready);
    predict_decimal_text(op);
    items_sent++;
  endtask

  // Waits until every expected character has arrived, then lets the back part settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Writes the buffer length while the block is idle.
  task automatic write_length(logic [6:0] value);
    cfg_we <= 1'b1;
    cfg_result_length <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    buffer_length = value;
  endtask

  // Receiver back-pressure: a random wait per character, one long hold-off.
  initial begin
    int wait_cycles;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_cycles = $urandom_range(0, 3);
      if (wait_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid && out_ready) begin
      chars_seen++;
      if (expected_text.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected character 0x%02h last=%0b ok=%0b", out_char, out_last, out_ok);
      end else begin
        want = expected_text.pop_front();
        if (out_char !== want.ch || out_last !== want.last || out_ok !== want.ok) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: char 0x%02h/0x%02h last %0b/%0b ok %0b/%0b (exp/act)",
                     want.ch, out_char, want.last, out_last, want.ok, out_ok);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    logic [6:0]    lengths[5];
    int            fill;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_result_length = mnmd_pkg::RESULT_LENGTH_RESET;
    in_valid = 1'b0;
    in_cmd = mnmd_pkg::CMD_MUL;
    in_whole_a = '0;
    in_num_a = '0;
    in_den_a = '0;
    in_whole_b = '0;
    in_num_b = '0;
    in_den_b = '0;
    buffer_length = mnmd_pkg::RESULT_LENGTH_RESET;
    mismatch_count = 0;
    chars_seen = 0;
    items_sent = 0;
    error_items = 0;
    long_hold = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows all use the predictor; error cases are also flagged and checked.
    rows = '{
      '{'{mnmd_pkg::CMD_MUL, 32'sd1, 31'd1, 31'd2, 32'sd2, 31'd0, 31'd1}, 1'b0},
      '{'{mnmd_pkg::CMD_DIV, 32'sd3, 31'd1, 31'd4, 32'sd1, 31'd1, 31'd2}, 1'b0},
      '{'{mnmd_pkg::CMD_MUL, -32'sd1, 31'd1, 31'd3, 32'sd1, 31'd0, 31'd1}, 1'b0},
      '{'{mnmd_pkg::CMD_DIV, -32'sd2, 31'd0, 31'd1, -32'sd3, 31'd0, 31'd1}, 1'b0},
      '{'{mnmd_pkg::CMD_MUL, -32'sd0, 31'd0, 31'd1, -32'sd1, 31'd0, 31'd1}, 1'b0},
      '{'{mnmd_pkg::CMD_MUL, 32'sd0, 31'd1, 31'd3, -32'sd1, 31'd0, 31'd5}, 1'b0},
      '{'{mnmd_pkg::CMD_MUL, 32'sd1, 31'd0, 31'd0, 32'sd1, 31'd0, 31'd1}, 1'b1},
      '{'{mnmd_pkg::CMD_DIV, 32'sd1, 31'd0, 31'd1, 32'sd1, 31'd0, 31'd0}, 1'b1},
      '{'{mnmd_pkg::CMD_DIV, 32'sd5, 31'd0, 31'd1, 32'sd0, 31'd0, 31'd7}, 1'b1},
      '{'{mnmd_pkg::CMD_MUL, 32'h7FFF_FFFF, 31'd0, 31'd1, 32'sd1, 31'd0, 31'd1}, 1'b0},
      '{'{mnmd_pkg::CMD_MUL, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sd1, 31'd0,
          31'd1}, 1'b1},
      '{'{mnmd_pkg::CMD_MUL, 32'sd70000, 31'd0, 31'd1, 32'sd70000, 31'd0, 31'd1}, 1'b1},
      '{'{mnmd_pkg::CMD_MUL, 32'sd1, 31'd0, 31'd70000, 32'sd1, 31'd0, 31'd70000}, 1'b1},
      '{'{mnmd_pkg::CMD_MUL, 32'sd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sd0, 31'd0, 31'd1},
        1'b0},
      '{'{mnmd_pkg::CMD_DIV, 32'sd0, 31'd1, 31'h7FFF_FFFF, 32'sd0, 31'd0, 31'd1}, 1'b1},
      '{'{mnmd_pkg::CMD_DIV, 32'sd22, 31'd0, 31'd1, 32'sd7, 31'd0, 31'd1}, 1'b0},
      '{'{mnmd_pkg::CMD_MUL, 32'sd123456, 31'd0, 31'd1, -32'sd100, 31'd0, 31'd1}, 1'b0}
    };

    // Walk the table at the reset length, then at short and extreme lengths.
    lengths = '{7'd16, 7'd1, 7'd3, 7'd64, 7'd127};
    foreach (lengths[li]) begin
      if (li != 0) write_length(lengths[li]);
      foreach (rows[ri]) begin
        row = rows[ri];
        send_item(row.ops);
        if (row.known_fail) begin
          // The last queued expectation must be an error terminator.
          fill = expected_text.size();
          if (fill == 0 || expected_text[fill - 1].ok !== 1'b0) begin
            mismatch_count++;
            $display("Directed row %0d not predicted as an error", ri);
          end
        end
      end
      drain_results();
    end

    // Random phases over several lengths, with one long receiver hold-off.
    lengths = '{7'd8, 7'd2, 7'd20, 7'd64, 7'd5};
    foreach (lengths[li]) begin
      write_length(lengths[li]);
      if (li == 1) long_hold = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / 5; n++) send_item(random_operands());
      drain_results();
    end

    $display("Sent %0d operations (%0d predicted errors), checked %0d characters",
             items_sent, error_items, chars_seen);
    $display("Lengths from 1 to 127 exercised, with receiver hold-off and idle gaps.");
    if (mismatch_count == 0 && expected_text.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d characters outstanding",
               mismatch_count, expected_text.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
